/* sv/salct_pkg.sv */
// ----------------------------------------------------------------------------
// salct_pkg
// Shared types and constants of the set-associative cache tag engine.
// ----------------------------------------------------------------------------
package salct_pkg;

    localparam int SET_BITS_CAP = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 4;
    localparam int WAYS_W       = 5;
    localparam int SFLD_W       = 8;
    localparam int TAG_W        = 32;
    localparam int STAMP_W      = 64;
    localparam int CNT_W        = 32;
    localparam int ADDR_W       = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 2'd2;

    typedef struct packed {
        logic              is_write;
        logic [TAG_W-1:0]  tag;
        logic [SFLD_W-1:0] set_field;
        logic [2:0]        ob;
        logic [3:0]        sb;
        logic [WAYS_W-1:0] ways;
        logic [ADDR_W-1:0] fill_addr;
    } t_item;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic               valid;
        logic               dirty;
        logic [STAMP_W-1:0] stamp;
    } t_line;

    localparam int LINE_W = $bits(t_line);

    typedef struct packed {
        logic              hit;
        logic [2:0]        way;
        logic              fill_needed;
        logic [ADDR_W-1:0] fill_addr;
        logic              wb_needed;
        logic [ADDR_W-1:0] wb_addr;
        logic [CNT_W-1:0]  miss_total;
        logic [CNT_W-1:0]  dirty_total;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_MIN
    } t_bstate;

endpackage

/* sv/salct_ram.sv */
// ----------------------------------------------------------------------------
// salct_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module salct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]   i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/salct_front.sv */
// ----------------------------------------------------------------------------
// salct_front
// Configuration registers and access decode into tag, set field and fill line.
// ----------------------------------------------------------------------------
module salct_front #(
    parameter int MAX_WAYS   = 8,
    parameter int ADDR_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [salct_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [salct_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_func,
    input  logic [salct_pkg::ADDR_W-1:0]        i_word_address,
    output salct_pkg::t_item                    o_item
);
    import salct_pkg::*;

    localparam logic [ADDR_W-1:0] AMASK = (ADDR_WIDTH >= ADDR_W) ? '1 :
        ADDR_W'((64'd1 << ADDR_WIDTH) - 64'd1);

    logic [3:0]        r_sb;
    logic [2:0]        r_ob;
    logic [3:0]        r_ways;
    logic [3:0]        sb_eff;
    logic [WAYS_W-1:0] ways_eff;
    logic [ADDR_W-1:0] addr;
    logic [4:0]        shamt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sb   <= '0;
            r_ob   <= '0;
            r_ways <= 4'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SET_BITS:    r_sb   <= i_cfg_data;
                CFG_OFFSET_BITS: r_ob   <= i_cfg_data[2:0];
                CFG_WAYS:        r_ways <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        sb_eff = (r_sb > 4'(SET_BITS_CAP)) ? 4'(SET_BITS_CAP) : r_sb;
        if (r_ways == '0) begin
            ways_eff = WAYS_W'(1);
        end else if (WAYS_W'(r_ways) > WAYS_W'(MAX_WAYS)) begin
            ways_eff = WAYS_W'(MAX_WAYS);
        end else begin
            ways_eff = WAYS_W'(r_ways);
        end
        addr  = i_word_address & AMASK;
        shamt = 5'(r_ob) + 5'(sb_eff);
        o_item.is_write  = i_func;
        o_item.tag       = addr >> shamt;
        o_item.set_field = SFLD_W'((addr >> r_ob) & ((32'd1 << sb_eff) - 32'd1));
        o_item.ob        = r_ob;
        o_item.sb        = sb_eff;
        o_item.ways      = ways_eff;
        o_item.fill_addr = addr & ~((32'd1 << r_ob) - 32'd1);
    end
endmodule

/* sv/salct_queue.sv */
// ----------------------------------------------------------------------------
// salct_queue
// Short queue of decoded accesses between front and back.
// ----------------------------------------------------------------------------
module salct_queue #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  salct_pkg::t_item i_item,
    input  logic             i_pop,
    output salct_pkg::t_item o_item,
    output logic             o_full,
    output logic             o_empty
);
    import salct_pkg::*;

    localparam int PW = $clog2(DEPTH > 1 ? DEPTH : 2);
    localparam int CW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end
endmodule

/* sv/salct_back.sv */
// ----------------------------------------------------------------------------
// salct_back
// Set lookup, hit detect, lru victim search and row update for one access.
// ----------------------------------------------------------------------------
module salct_back #(
    parameter int MAX_WAYS   = 8,
    parameter int MAX_SETS   = 256,
    parameter int ADDR_WIDTH = 32
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_empty,
    input  salct_pkg::t_item                                i_item,
    output logic                                            o_pop,
    output logic                                            o_ram_re,
    output logic [$clog2(MAX_SETS > 1 ? MAX_SETS : 2)-1:0]  o_ram_raddr,
    input  logic [MAX_WAYS*salct_pkg::LINE_W-1:0]           i_ram_rdata,
    output logic                                            o_ram_we,
    output logic [$clog2(MAX_SETS > 1 ? MAX_SETS : 2)-1:0]  o_ram_waddr,
    output logic [MAX_WAYS*salct_pkg::LINE_W-1:0]           o_ram_wdata,
    output logic                                            o_valid,
    output salct_pkg::t_result                              o_res
);
    import salct_pkg::*;

    localparam int SET_W = $clog2(MAX_SETS > 1 ? MAX_SETS : 2);
    localparam int WAY_W = $clog2(MAX_WAYS > 1 ? MAX_WAYS : 2);
    localparam int LV    = $clog2(MAX_WAYS);
    localparam int NP    = 1 << LV;
    localparam int LVL_W = $clog2(LV + 1 > 1 ? LV + 1 : 2);
    localparam logic [ADDR_W-1:0] AMASK = (ADDR_WIDTH >= ADDR_W) ? '1 :
        ADDR_W'((64'd1 << ADDR_WIDTH) - 64'd1);

    logic [SET_W-1:0] set_tab [2**SFLD_W];

    for (genvar g = 0; g < 2**SFLD_W; g++) begin : g_tab
        assign set_tab[g] = SET_W'(g % MAX_SETS);
    end

    t_bstate                     r_state, n_state;
    t_item                       r_item, n_item;
    logic [SET_W-1:0]            r_set, n_set;
    t_line [MAX_WAYS-1:0]        r_row, n_row;
    logic                        r_hit, n_hit;
    logic [WAY_W-1:0]            r_hway, n_hway;
    logic                        r_anyinv, n_anyinv;
    logic [WAY_W-1:0]            r_iway, n_iway;
    logic [STAMP_W-1:0]          r_cs [NP];
    logic [STAMP_W-1:0]          n_cs [NP];
    logic [WAY_W-1:0]            r_cw [NP];
    logic [WAY_W-1:0]            n_cw [NP];
    logic [NP-1:0]               r_ce, n_ce;
    logic [LVL_W-1:0]            r_lvl, n_lvl;
    logic [STAMP_W-1:0]          r_acc, n_acc;
    logic [CNT_W-1:0]            r_miss, n_miss;
    logic [CNT_W-1:0]            r_dirty, n_dirty;
    logic [MAX_SETS-1:0]         r_row_ok, n_row_ok;
    logic                        r_valid, n_valid;
    t_result                     r_res, n_res;

    t_line [MAX_WAYS-1:0]        rd_row;
    t_line [MAX_WAYS-1:0]        lk_row;
    logic [MAX_WAYS-1:0]         lk_en;
    logic                        lk_hit;
    logic [WAY_W-1:0]            lk_hway;
    logic                        lk_inv;
    logic [WAY_W-1:0]            lk_iway;
    logic [WAY_W-1:0]            f_way;
    t_line                       f_vic;
    t_line                       f_new;
    logic                        f_wb;
    logic [4:0]                  f_shamt;
    logic [STAMP_W-1:0]          f_stamp;
    t_line [MAX_WAYS-1:0]        f_row;

    assign rd_row = i_ram_rdata;

    // lookup on the row just read
    always_comb begin
        lk_hit  = 1'b0;
        lk_hway = '0;
        lk_inv  = 1'b0;
        lk_iway = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            lk_row[w] = rd_row[w];
            if (!r_row_ok[r_set]) begin
                lk_row[w].valid = 1'b0;
                lk_row[w].dirty = 1'b0;
                lk_row[w].stamp = '0;
            end
            lk_en[w] = (WAYS_W'(w) < r_item.ways);
        end
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (lk_en[w] && lk_row[w].valid && lk_row[w].tag == r_item.tag) begin
                lk_hit  = 1'b1;
                lk_hway = WAY_W'(w);
            end
            if (lk_en[w] && !lk_row[w].valid) begin
                lk_inv  = 1'b1;
                lk_iway = WAY_W'(w);
            end
        end
    end

    // final update of the chosen way
    always_comb begin
        f_way   = r_hit ? r_hway : (r_anyinv ? r_iway : r_cw[0]);
        f_vic   = r_row[f_way];
        f_wb    = !r_hit && f_vic.valid && f_vic.dirty;
        f_shamt = 5'(r_item.ob) + 5'(r_item.sb);
        f_stamp = r_acc + 1'b1;
        if (r_hit) begin
            f_new       = f_vic;
            f_new.dirty = f_vic.dirty | r_item.is_write;
            f_new.stamp = f_stamp;
        end else begin
            f_new.tag   = r_item.tag;
            f_new.valid = 1'b1;
            f_new.dirty = r_item.is_write;
            f_new.stamp = f_stamp;
        end
        f_row        = r_row;
        f_row[f_way] = f_new;
    end

    always_comb begin
        n_state  = r_state;
        n_item   = r_item;
        n_set    = r_set;
        n_row    = r_row;
        n_hit    = r_hit;
        n_hway   = r_hway;
        n_anyinv = r_anyinv;
        n_iway   = r_iway;
        n_cs     = r_cs;
        n_cw     = r_cw;
        n_ce     = r_ce;
        n_lvl    = r_lvl;
        n_acc    = r_acc;
        n_miss   = r_miss;
        n_dirty  = r_dirty;
        n_row_ok = r_row_ok;
        n_valid  = 1'b0;
        n_res    = r_res;
        o_pop       = 1'b0;
        o_ram_re    = 1'b0;
        o_ram_raddr = set_tab[i_item.set_field];
        o_ram_we    = 1'b0;
        o_ram_waddr = r_set;
        o_ram_wdata = f_row;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop    = 1'b1;
                    o_ram_re = 1'b1;
                    n_item   = i_item;
                    n_set    = set_tab[i_item.set_field];
                    n_state  = S_LOOK;
                end
            end
            S_LOOK: begin
                n_row    = lk_row;
                n_hit    = lk_hit;
                n_hway   = lk_hway;
                n_anyinv = lk_inv;
                n_iway   = lk_iway;
                for (int i = 0; i < NP; i++) begin
                    if (i < MAX_WAYS) begin
                        n_cs[i] = lk_row[i].stamp;
                        n_ce[i] = lk_en[i];
                    end else begin
                        n_cs[i] = '0;
                        n_ce[i] = 1'b0;
                    end
                    n_cw[i] = WAY_W'(i);
                end
                n_lvl   = '0;
                n_state = S_MIN;
            end
            S_MIN: begin
                if (r_lvl != LVL_W'(LV)) begin
                    for (int i = 0; i < NP / 2; i++) begin
                        if (r_ce[2*i+1] && (!r_ce[2*i] || r_cs[2*i+1] < r_cs[2*i])) begin
                            n_cs[i] = r_cs[2*i+1];
                            n_cw[i] = r_cw[2*i+1];
                            n_ce[i] = 1'b1;
                        end else begin
                            n_cs[i] = r_cs[2*i];
                            n_cw[i] = r_cw[2*i];
                            n_ce[i] = r_ce[2*i];
                        end
                    end
                    n_lvl = r_lvl + 1'b1;
                end else begin
                    o_ram_we          = 1'b1;
                    n_row_ok[r_set]   = 1'b1;
                    n_acc             = f_stamp;
                    n_miss            = r_miss + CNT_W'(!r_hit);
                    n_dirty           = r_dirty + CNT_W'(f_wb);
                    n_valid           = 1'b1;
                    n_res.hit         = r_hit;
                    n_res.way         = 3'(f_way);
                    n_res.fill_needed = !r_hit;
                    n_res.fill_addr   = r_hit ? '0 : r_item.fill_addr;
                    n_res.wb_needed   = f_wb;
                    n_res.wb_addr     = f_wb ? (((f_vic.tag << f_shamt) |
                        (ADDR_W'(r_item.set_field) << r_item.ob)) & AMASK) : '0;
                    n_res.miss_total  = n_miss;
                    n_res.dirty_total = n_dirty;
                    n_state           = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_lvl    <= '0;
            r_acc    <= '0;
            r_miss   <= '0;
            r_dirty  <= '0;
            r_row_ok <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_lvl    <= n_lvl;
            r_acc    <= n_acc;
            r_miss   <= n_miss;
            r_dirty  <= n_dirty;
            r_row_ok <= n_row_ok;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_set    <= n_set;
        r_row    <= n_row;
        r_hit    <= n_hit;
        r_hway   <= n_hway;
        r_anyinv <= n_anyinv;
        r_iway   <= n_iway;
        r_cs     <= n_cs;
        r_cw     <= n_cw;
        r_ce     <= n_ce;
        r_res    <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule

/* sv/set_assoc_lru_cache_tags.sv */
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags
// Tag and lru policy engine of a write-allocate, write-back set-assoc cache.
//
// channel   | handshake             | payload
// ----------+-----------------------+-----------------------------------------
// access    | start / busy          | i_func, i_word_address
// result    | o_valid (one cycle)   | o_hit .. o_dirty_eviction_total
// config    | i_cfg_we              | i_cfg_idx, i_cfg_data
//
// each access passes through the back end in order: one tag row read, one lookup,
// one lru tree level per cycle, one row write.
// a two-entry queue decouples decode from lookup; busy rises when it is full.
// reset is synchronous; sets never written since reset read as empty.
// results are strobed for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tags #(
    parameter int MAX_WAYS   = 8,
    parameter int MAX_SETS   = 256,
    parameter int ADDR_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [salct_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [salct_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_func,
    input  logic [31:0]                       i_word_address,
    output logic                              o_valid,
    output logic                              o_hit,
    output logic [2:0]                        o_way_used,
    output logic                              o_fill_needed,
    output logic [31:0]                       o_fill_line_address,
    output logic                              o_writeback_needed,
    output logic [31:0]                       o_writeback_line_address,
    output logic [31:0]                       o_miss_total,
    output logic [31:0]                       o_dirty_eviction_total
);
    import salct_pkg::*;

    localparam int SET_W = $clog2(MAX_SETS > 1 ? MAX_SETS : 2);
    localparam int ROW_W = MAX_WAYS * LINE_W;

    t_item            dec_item;
    t_item            q_item;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;
    logic             push;
    logic             ram_re;
    logic [SET_W-1:0] ram_raddr;
    logic [ROW_W-1:0] ram_rdata;
    logic             ram_we;
    logic [SET_W-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    t_result          res;

    assign busy = q_full | !i_rst_n;
    assign push = start & !busy;

    salct_front #(
        .MAX_WAYS  (MAX_WAYS),
        .ADDR_WIDTH(ADDR_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_func        (i_func),
        .i_word_address(i_word_address),
        .o_item        (dec_item)
    );

    salct_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_item (dec_item),
        .i_pop  (q_pop),
        .o_item (q_item),
        .o_full (q_full),
        .o_empty(q_empty)
    );

    salct_ram #(
        .WIDTH(ROW_W),
        .DEPTH(MAX_SETS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    salct_back #(
        .MAX_WAYS  (MAX_WAYS),
        .MAX_SETS  (MAX_SETS),
        .ADDR_WIDTH(ADDR_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (q_empty),
        .i_item     (q_item),
        .o_pop      (q_pop),
        .o_ram_re   (ram_re),
        .o_ram_raddr(ram_raddr),
        .i_ram_rdata(ram_rdata),
        .o_ram_we   (ram_we),
        .o_ram_waddr(ram_waddr),
        .o_ram_wdata(ram_wdata),
        .o_valid    (o_valid),
        .o_res      (res)
    );

    assign o_hit                    = res.hit;
    assign o_way_used               = res.way;
    assign o_fill_needed            = res.fill_needed;
    assign o_fill_line_address      = res.fill_addr;
    assign o_writeback_needed       = res.wb_needed;
    assign o_writeback_line_address = res.wb_addr;
    assign o_miss_total             = res.miss_total;
    assign o_dirty_eviction_total   = res.dirty_total;
endmodule

/* sv/salct_checker.sv */
// ----------------------------------------------------------------------------
// salct_checker
// Port-level checks on result strobes and result field consistency.
// ----------------------------------------------------------------------------
module salct_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        o_hit,
    input logic        o_fill_needed,
    input logic [31:0] o_fill_line_address,
    input logic        o_writeback_needed,
    input logic [31:0] o_writeback_line_address
);
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    a_hit_xor_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hit != o_fill_needed))
        else $error("hit and fill disagree");

    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> (!o_writeback_needed && o_fill_line_address == 32'd0))
        else $error("hit reports fill or writeback");

    a_wb_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_writeback_needed) |-> (o_writeback_line_address == 32'd0))
        else $error("writeback address without writeback");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result after reset");
endmodule

bind set_assoc_lru_cache_tags salct_checker u_salct_checker (.*);
